/* src/hckl_pkg.sv */
// Shared types and constants for the hash-chain key leaf generator.
`default_nettype none
package hckl_pkg;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_LOAD_WAIT,
		S_HASH_SETUP,
		S_HASH_START,
		S_HASH_WAIT,
		S_HASH_TAKE,
		S_STORE,
		S_LEAF_INIT,
		S_FEED,
		S_FEED_WAIT,
		S_LEAF_START,
		S_LEAF_WAIT,
		S_OUT,
		S_OUT_WAIT,
		S_OUT_EMIT,
		S_LEAF_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD_CHAIN,
		OP_STORE_CHAIN,
		OP_CHAIN_BLOCK,
		OP_TMP_DIGEST,
		OP_FEED_LEAF,
		OP_OUT_BYTE,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   sec_we;
		logic   sha_init;
		logic   sha_start;
		logic   emit_leaf;
		logic   emit_last;
	} cmd_t;

	typedef struct packed {
		logic sha_done;
	} sts_t;

	localparam logic [15:0] CHAIN_LENGTH_RESET = 16'hFFFF;
	localparam int          LEAF_WORDS         = 4;

	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

/* src/hckl_sha.sv */
// SHA-256 compression unit, one round per cycle.
`default_nettype none
module hckl_sha (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         init,
	input  wire logic         start,
	input  wire logic [511:0] block,
	output logic      [255:0] digest,
	output logic              done
);
	import hckl_pkg::*;

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [6:0]  rnd_q;
	logic        run_q;
	logic        fin_q;
	logic        done_q;

	logic [31:0] t1, t2, w_new;

	always_comb begin
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + SHA_K[rnd_q[5:0]] + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
			+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q  <= '0;
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= '0;
		end else begin
			done_q <= 1'b0;
			if (init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= SHA_IV[255 - 32*i -: 32];
			end
			if (start) begin
				rnd_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	// working variables and message schedule window
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
		end else if (run_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) digest[255 - 32*i -: 32] = h_q[i];
	end
	assign done = done_q;

endmodule
`default_nettype wire

/* src/hckl_dp.sv */
// Datapath: key and public-key memories, chain value, message block, output register.
`default_nettype none
module hckl_dp #(
	parameter int CHAINS      = 18,
	parameter int CHAIN_BYTES = 24,
	localparam int KB  = CHAINS * CHAIN_BYTES,
	localparam int KW  = (KB + 7) / 8,
	localparam int L   = ((KB + 8) / 64 + 1) * 64,
	localparam int PW  = $clog2(L + 1),
	localparam int SAW = (KW > 1) ? $clog2(KW) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hckl_pkg::cmd_t  cmd,
	input  wire logic [PW-1:0]   pos,
	input  wire logic [SAW-1:0]  wa,
	input  wire logic [63:0]     key_word,
	output hckl_pkg::sts_t       sts,
	output logic                 out_valid,
	output logic [63:0]          out_word,
	output logic                 out_kind,
	output logic                 out_last
);
	import hckl_pkg::*;

	localparam int          PAW       = $clog2(KB);
	localparam int          TW        = CHAIN_BYTES * 8;
	localparam int          ZW        = (56 - CHAIN_BYTES - 1) * 8;
	localparam logic [63:0] LEAF_LEN  = 64'(KB * 8);
	localparam logic [63:0] CHAIN_LEN = 64'(CHAIN_BYTES * 8);

	logic [63:0]   sec_mem [KW];
	logic [7:0]    pub_mem [KB];
	logic [63:0]   sec_rd_q;
	logic [7:0]    pub_rd_q;
	dp_op_t        op_s1;
	logic [PW-1:0] pos_s1;
	logic          key_s1;
	logic [TW-1:0] tmp_q;
	logic [511:0]  blk_q;
	logic [63:0]   wrd_q;
	logic [63:0]   out_word_q;
	logic          out_kind_q;
	logic          out_last_q;
	logic          out_valid_q;

	logic [255:0]  digest;
	logic          sha_done;
	logic          in_key;
	logic [PAW-1:0] pub_addr;
	logic [7:0]    sec_byte;
	logic [7:0]    pad_byte;
	logic [2:0]    len_idx;
	logic [511:0]  chain_blk;

	assign in_key   = pos < PW'(KB);
	assign pub_addr = PAW'(pos);

	hckl_sha u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (cmd.sha_init),
		.start  (cmd.sha_start),
		.block  (blk_q),
		.digest (digest),
		.done   (sha_done)
	);

	assign sts.sha_done = sha_done;

	// single-block padding of one chain value
	assign chain_blk = {tmp_q, 8'h80, {ZW{1'b0}}, CHAIN_LEN};

	always_comb begin
		sec_byte = 8'(sec_rd_q >> {~pos_s1[2:0], 3'b000});
		len_idx  = 3'(PW'(L - 1) - pos_s1);
		if (pos_s1 == PW'(KB)) begin
			pad_byte = 8'h80;
		end else if (pos_s1 >= PW'(L - 8)) begin
			pad_byte = 8'(LEAF_LEN >> {len_idx, 3'b000});
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sec_we) sec_mem[wa] <= key_word;
		if (cmd.op == OP_LOAD_CHAIN) sec_rd_q <= sec_mem[SAW'(pos >> 3)];
		if (cmd.op == OP_STORE_CHAIN) pub_mem[pub_addr] <= tmp_q[TW-1 -: 8];
		if ((cmd.op == OP_FEED_LEAF || cmd.op == OP_OUT_BYTE) && in_key) begin
			pub_rd_q <= pub_mem[pub_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			op_s1       <= cmd.op;
			out_valid_q <= cmd.op == OP_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos;
		key_s1 <= in_key;

		if (op_s1 == OP_LOAD_CHAIN) begin
			tmp_q <= {tmp_q[TW-9:0], sec_byte};
		end else if (cmd.op == OP_STORE_CHAIN) begin
			tmp_q <= {tmp_q[TW-9:0], 8'h00};
		end else if (cmd.op == OP_TMP_DIGEST) begin
			tmp_q <= digest[255 -: TW];
		end

		if (cmd.op == OP_CHAIN_BLOCK) begin
			blk_q <= chain_blk;
		end else if (op_s1 == OP_FEED_LEAF) begin
			blk_q <= {blk_q[503:0], key_s1 ? pub_rd_q : pad_byte};
		end

		if (op_s1 == OP_OUT_BYTE) begin
			wrd_q <= {wrd_q[55:0], key_s1 ? pub_rd_q : 8'h00};
		end

		if (cmd.op == OP_EMIT) begin
			out_word_q <= cmd.emit_leaf ? 64'(digest >> {~pos[1:0], 6'b000000}) : wrd_q;
			out_kind_q <= cmd.emit_leaf;
			out_last_q <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

/* src/hckl_ctrl.sv */
// Controller: key loading, chain stepping, leaf hashing and result sequencing.
`default_nettype none
module hckl_ctrl #(
	parameter int CHAINS      = 18,
	parameter int CHAIN_BYTES = 24,
	localparam int KB  = CHAINS * CHAIN_BYTES,
	localparam int KW  = (KB + 7) / 8,
	localparam int L   = ((KB + 8) / 64 + 1) * 64,
	localparam int PW  = $clog2(L + 1),
	localparam int SAW = (KW > 1) ? $clog2(KW) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           key_last,
	input  wire logic           cfg_we,
	input  wire logic [15:0]    cfg_data,
	input  wire hckl_pkg::sts_t sts,
	output logic                busy,
	output hckl_pkg::cmd_t      cmd,
	output logic [PW-1:0]       pos,
	output logic [SAW-1:0]      wa
);
	import hckl_pkg::*;

	localparam int LW  = $clog2(KW + 1);
	localparam int CIW = (CHAINS > 1) ? $clog2(CHAINS) : 1;
	localparam int CBW = $clog2(CHAIN_BYTES);

	state_t         state_q, state_d;
	logic [15:0]    chain_length_q;
	logic [LW-1:0]  load_q, load_d;
	logic [CIW-1:0] ci_q, ci_d;
	logic [PW-1:0]  base_q, base_d;
	logic [CBW-1:0] j_q, j_d;
	logic [15:0]    step_q, step_d;
	logic [PW-1:0]  p_q, p_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_length_q <= CHAIN_LENGTH_RESET;
			load_q         <= '0;
			ci_q           <= '0;
			base_q         <= '0;
			j_q            <= '0;
			step_q         <= '0;
			p_q            <= '0;
		end else begin
			if (cfg_we) chain_length_q <= cfg_data;
			load_q <= load_d;
			ci_q   <= ci_d;
			base_q <= base_d;
			j_q    <= j_d;
			step_q <= step_d;
			p_q    <= p_d;
		end
	end

	always_comb begin
		state_d = state_q;
		load_d  = load_q;
		ci_d    = ci_q;
		base_d  = base_q;
		j_d     = j_q;
		step_d  = step_q;
		p_d     = p_q;
		cmd     = '0;
		cmd.op  = OP_NONE;
		pos     = '0;
		wa      = SAW'(load_q);
		busy    = state_q != S_IDLE;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.sec_we = load_q < LW'(KW);
					if (key_last) begin
						load_d  = '0;
						ci_d    = '0;
						base_d  = '0;
						j_d     = '0;
						state_d = S_LOAD;
					end else if (load_q < LW'(KW)) begin
						load_d = load_q + LW'(1);
					end
				end
			end
			S_LOAD: begin
				cmd.op = OP_LOAD_CHAIN;
				pos    = base_q + PW'(j_q);
				if (j_q == CBW'(CHAIN_BYTES - 1)) begin
					j_d     = '0;
					state_d = S_LOAD_WAIT;
				end else begin
					j_d = j_q + CBW'(1);
				end
			end
			S_LOAD_WAIT: begin
				step_d  = '0;
				state_d = (chain_length_q == 16'd0) ? S_STORE : S_HASH_SETUP;
			end
			S_HASH_SETUP: begin
				cmd.op       = OP_CHAIN_BLOCK;
				cmd.sha_init = 1'b1;
				state_d      = S_HASH_START;
			end
			S_HASH_START: begin
				cmd.sha_start = 1'b1;
				state_d       = S_HASH_WAIT;
			end
			S_HASH_WAIT: begin
				if (sts.sha_done) state_d = S_HASH_TAKE;
			end
			S_HASH_TAKE: begin
				cmd.op  = OP_TMP_DIGEST;
				step_d  = step_q + 16'd1;
				state_d = (step_q == chain_length_q - 16'd1) ? S_STORE : S_HASH_SETUP;
			end
			S_STORE: begin
				cmd.op = OP_STORE_CHAIN;
				pos    = base_q + PW'(j_q);
				if (j_q == CBW'(CHAIN_BYTES - 1)) begin
					j_d    = '0;
					base_d = base_q + PW'(CHAIN_BYTES);
					if (ci_q == CIW'(CHAINS - 1)) begin
						p_d     = '0;
						state_d = S_LEAF_INIT;
					end else begin
						ci_d    = ci_q + CIW'(1);
						state_d = S_LOAD;
					end
				end else begin
					j_d = j_q + CBW'(1);
				end
			end
			S_LEAF_INIT: begin
				cmd.sha_init = 1'b1;
				state_d      = S_FEED;
			end
			S_FEED: begin
				cmd.op = OP_FEED_LEAF;
				pos    = p_q;
				p_d    = p_q + PW'(1);
				if (p_q[5:0] == 6'd63) state_d = S_FEED_WAIT;
			end
			S_FEED_WAIT: begin
				state_d = S_LEAF_START;
			end
			S_LEAF_START: begin
				cmd.sha_start = 1'b1;
				state_d       = S_LEAF_WAIT;
			end
			S_LEAF_WAIT: begin
				if (sts.sha_done) begin
					if (p_q == PW'(L)) begin
						p_d     = '0;
						state_d = S_OUT;
					end else begin
						state_d = S_FEED;
					end
				end
			end
			S_OUT: begin
				cmd.op = OP_OUT_BYTE;
				pos    = p_q;
				p_d    = p_q + PW'(1);
				if (p_q[2:0] == 3'd7) state_d = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				state_d = S_OUT_EMIT;
			end
			S_OUT_EMIT: begin
				cmd.op = OP_EMIT;
				if (p_q == PW'(KW * 8)) begin
					j_d     = '0;
					state_d = S_LEAF_EMIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_LEAF_EMIT: begin
				cmd.op        = OP_EMIT;
				cmd.emit_leaf = 1'b1;
				pos           = PW'(j_q[1:0]);
				if (j_q[1:0] == 2'(LEAF_WORDS - 1)) begin
					cmd.emit_last = 1'b1;
					j_d           = '0;
					state_d       = S_IDLE;
				end else begin
					j_d = j_q + CBW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/hash_chain_key_leaf_generator.sv */
// Top level of the hash-chain key leaf generator.
//
// Usage: a secret key of CHAINS chains of CHAIN_BYTES bytes is loaded one 64-bit word
// per transaction (start high while busy is low), first byte in key_word[63:56].
// The word flagged with key_last launches the run. Words beyond the key size are dropped.
// Each chain value is hashed chain_length times with SHA-256 (digest cut to CHAIN_BYTES),
// then the public-key words are emitted (out_kind 0), followed by the four words of the
// SHA-256 leaf digest over the whole public key (out_kind 1, out_last on the fourth).
// Each result shows on out_word/out_kind/out_last for one cycle with out_valid high;
// the receiver cannot stall, so results leave on a fixed schedule.
// chain_length is written through cfg_we/cfg_data while busy is low.
//
// Run: each chain value takes chain_length hash steps, the leaf hash covers the padded
// public key in 64-byte blocks (7 leaf blocks at the defaults), and the run's length
// is set by the SHA-256 unit that does one round per cycle.
// busy stays high from the launching word and drops as the last leaf word is strobed.
// Reset (arst_n low) returns to idle, sets chain_length to 65535 and clears the load
// count; the key memory holds no defined contents until written.
`default_nettype none
module hash_chain_key_leaf_generator #(
	parameter int CHAINS      = 18,
	parameter int CHAIN_BYTES = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] key_word,
	input  wire logic        key_last,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	output logic [63:0]      out_word,
	output logic             out_kind,
	output logic             out_last
);
	import hckl_pkg::*;

	localparam int KB  = CHAINS * CHAIN_BYTES;
	localparam int KW  = (KB + 7) / 8;
	localparam int L   = ((KB + 8) / 64 + 1) * 64;
	localparam int PW  = $clog2(L + 1);
	localparam int SAW = (KW > 1) ? $clog2(KW) : 1;

	cmd_t           cmd;
	sts_t           sts;
	logic [PW-1:0]  pos;
	logic [SAW-1:0] wa;

	// sequencing: counters, config register, command issue
	hckl_ctrl #(
		.CHAINS      (CHAINS),
		.CHAIN_BYTES (CHAIN_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.key_last (key_last),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd),
		.pos      (pos),
		.wa       (wa)
	);

	// storage, byte steering, hash unit and result register
	hckl_dp #(
		.CHAINS      (CHAINS),
		.CHAIN_BYTES (CHAIN_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pos       (pos),
		.wa        (wa),
		.key_word  (key_word),
		.sts       (sts),
		.out_valid (out_valid),
		.out_word  (out_word),
		.out_kind  (out_kind),
		.out_last  (out_last)
	);

endmodule
`default_nettype wire

/* src/hckl_chk.sv */
// Port-level checker for the hash-chain key leaf generator, with its bind.
`default_nettype none
module hckl_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        key_last,
	input wire logic        out_valid,
	input wire logic        out_kind,
	input wire logic        out_last
);

	// last word is always a leaf word
	a_last_is_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_kind)
		else $error("out_last on a public-key word");

	// every result but the final one comes while the run is still busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> busy)
		else $error("result strobed outside a run");

	// the run ends exactly with the last leaf word
	a_end_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> out_valid && out_last)
		else $error("busy dropped without final leaf word");

	// leaf words come back to back
	a_leaf_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind && !out_last |=> out_valid && out_kind)
		else $error("gap inside leaf digest burst");

	// a key word without key_last only loads, it never launches a run
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !key_last |=> !busy)
		else $error("run launched by a word without key_last");

endmodule

bind hash_chain_key_leaf_generator hckl_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.key_last  (key_last),
	.out_valid (out_valid),
	.out_kind  (out_kind),
	.out_last  (out_last)
);
`default_nettype wire

/* tb/tb.sv */
// Testbench for hash_chain_key_leaf_generator: chained SHA-256 public key and leaf check.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_WORDS = 54;
	localparam int CHAINS    = 18;
	localparam int WDOG_MAX  = 60000; // cycles with no transaction

	// filler patterns for key words
	localparam int PAT_ONES  = 0;
	localparam int PAT_ZERO  = 1;
	localparam int PAT_ALT   = 2;
	localparam int PAT_RAND  = 3;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [63:0] word;
		logic        kind;
		logic        last;
	} out_item_t;

	// one directed run: chain length, word count, filler, sender idle percent
	typedef struct {
		logic [15:0] steps;
		int          words;
		int          pat;
		int          idle_pct;
	} run_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] key_word = '0;
	logic        key_last = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        out_valid;
	logic [63:0] out_word;
	logic        out_kind;
	logic        out_last;

	// predictor state
	logic [63:0] key_mem [KEY_WORDS];
	int          fill_count;
	logic [15:0] chain_steps;
	out_item_t   pending_q[$];

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int runs_done = 0;
	int wdog = 0;

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	hash_chain_key_leaf_generator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.key_word(key_word), .key_last(key_last),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_word(out_word), .out_kind(out_kind), .out_last(out_last)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// full SHA-256 over a byte string, digest first byte in the top bits
	function automatic logic [255:0] sha256_of(input byte_q_t msg);
		byte_q_t     m;
		logic [63:0] bitlen;
		logic [31:0] h [8];
		logic [31:0] v [8];
		logic [31:0] w [64];
		logic [31:0] t1, t2;
		logic [255:0] d;
		m = msg;
		bitlen = 64'(msg.size()) * 8;
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		m.push_back(8'h80);
		while (m.size() % 64 != 56) m.push_back(8'h00);
		for (int i = 7; i >= 0; i--) m.push_back(bitlen[8*i +: 8]);
		for (int blk = 0; blk < m.size(); blk += 64) begin
			for (int i = 0; i < 16; i++)
				w[i] = {m[blk+4*i], m[blk+4*i+1], m[blk+4*i+2], m[blk+4*i+3]};
			for (int i = 16; i < 64; i++)
				w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
				     + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
			v = h;
			for (int r = 0; r < 64; r++) begin
				t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[r] + w[r];
				t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
		end
		for (int i = 0; i < 8; i++) d[255 - 32*i -: 32] = h[i];
		return d;
	endfunction

	// load one key word; on the final word compute public key and leaf
	task automatic key_predict(input logic [63:0] w, input logic l);
		logic [191:0] chain_val;
		logic [255:0] dig;
		logic [63:0]  pub [KEY_WORDS];
		byte_q_t      buf_q;
		if (fill_count < KEY_WORDS) begin
			key_mem[fill_count] = w;
			fill_count++;
		end
		if (!l) return;
		for (int c = 0; c < CHAINS; c++) begin
			chain_val = {key_mem[3*c], key_mem[3*c+1], key_mem[3*c+2]};
			for (int s = 0; s < chain_steps; s++) begin
				buf_q = {};
				for (int b = 23; b >= 0; b--) buf_q.push_back(chain_val[8*b +: 8]);
				dig = sha256_of(buf_q);
				chain_val = dig[255 -: 192];
			end
			{pub[3*c], pub[3*c+1], pub[3*c+2]} = chain_val;
		end
		buf_q = {};
		for (int k = 0; k < KEY_WORDS; k++) begin
			pending_q.push_back('{pub[k], 1'b0, 1'b0});
			for (int b = 7; b >= 0; b--) buf_q.push_back(pub[k][8*b +: 8]);
		end
		dig = sha256_of(buf_q);
		for (int k = 0; k < 4; k++)
			pending_q.push_back('{dig[255 - 64*k -: 64], 1'b1, k == 3});
		fill_count = 0;
	endtask

	// one transaction; random gap first, then hold start until accepted
	task automatic put_word(input logic [63:0] w, input logic l, input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start    <= 1'b1;
		key_word <= w;
		key_last <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		key_predict(w, l);
		words_sent++;
	endtask

	function automatic logic [63:0] fill_word(input int pat, input int k);
		case (pat)
			PAT_ONES: return '1;
			PAT_ZERO: return '0;
			PAT_ALT:  return k[0] ? 64'haaaa_aaaa_aaaa_aaaa : 64'h5555_5555_5555_5555;
			default:  return {$urandom, $urandom};
		endcase
	endfunction

	// drain, reconfigure while idle, then send one key
	task automatic key_run(input logic [15:0] steps, input int words, input int pat,
			input int idle_pct);
		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= steps;
		@(posedge clk);
		cfg_we   <= 1'b0;
		chain_steps = steps;
		for (int k = 0; k < words; k++)
			put_word(fill_word(pat, k), k == words - 1, idle_pct);
		runs_done++;
	endtask

	// result checker: the receiver never stalls, every strobe is a transaction
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result word=%h kind=%b last=%b",
					$time, out_word, out_kind, out_last);
				errors++;
			end else begin
				exp_item = pending_q.pop_front();
				if (out_word !== exp_item.word) begin
					$display("%0t: out_word expected %h actual %h", $time, exp_item.word, out_word);
					errors++;
				end
				if (out_kind !== exp_item.kind) begin
					$display("%0t: out_kind expected %b actual %b", $time, exp_item.kind, out_kind);
					errors++;
				end
				if (out_last !== exp_item.last) begin
					$display("%0t: out_last expected %b actual %b", $time, exp_item.last, out_last);
					errors++;
				end
			end
		end
	end

	// watchdog over cycles that move no transaction in either direction
	always @(posedge clk) begin
		if ((start && !busy) || out_valid || !arst_n)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("%0t: watchdog expired, %0d results still pending", $time, pending_q.size());
			$display("[hash_chain_key_leaf_generator] ERROR");
			$finish;
		end
	end

	run_row_t dir_rows [] = '{
		// full key of ones plus two words past the slots, no hashing:
		// the extra words drop and the public key echoes the secret key
		'{16'd0, KEY_WORDS + 2, PAT_ONES, 0},
		// short key after a full one: untouched slots keep the ones
		'{16'd1, 1, PAT_ZERO, 0},
		'{16'd2, 3, PAT_ALT, 0}
	};

	initial begin
		int idle_tab [4] = '{0, 49, 0, 18};
		int n, steps;
		for (int k = 0; k < KEY_WORDS; k++) key_mem[k] = '0;
		fill_count  = 0;
		chain_steps = 16'hFFFF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// write the top extreme once and move on
		cfg_we   <= 1'b1;
		cfg_data <= 16'hFFFF;
		@(posedge clk);
		cfg_we   <= 1'b0;

		foreach (dir_rows[i])
			key_run(dir_rows[i].steps, dir_rows[i].words, dir_rows[i].pat, dir_rows[i].idle_pct);

		// random short keys over the slots loaded so far
		for (int r = 0; r < 6 || words_sent < 100; r++) begin
			n = $urandom_range(10, 1);
			steps = (r % 4 == 3) ? $urandom_range(5, 0) : $urandom_range(2, 0);
			key_run(16'(steps), n, PAT_RAND, idle_tab[r % 4]);
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0 || busy) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d key runs, %0d key words sent, %0d result words checked.",
			runs_done, words_sent, results_seen);
		$display("Chain lengths 0..5, short and overfull keys, sender idle 0/18/49 percent.");
		if (errors == 0)
			$display("[hash_chain_key_leaf_generator] OK");
		else
			$display("[hash_chain_key_leaf_generator] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
src/hckl_pkg.sv
src/hckl_sha.sv
src/hckl_dp.sv
src/hckl_ctrl.sv
src/hash_chain_key_leaf_generator.sv
src/hckl_chk.sv
tb/tb.sv
